>>> hdl/pfrm_pkg.sv
package pfrm_pkg;

	// defaults for the top-level parameters
	localparam int PAGES_DEF      = 4096;
	localparam int PAGE_BITS_DEF  = 12;
	localparam int STAMP_BITS_DEF = 56;

	// request and result field widths
	localparam int ADDR_W     = 48;
	localparam int NOW_W      = 56;
	localparam int PAGE_OUT_W = 12;
	localparam int STATUS_W   = 2;

	// configuration register widths
	localparam int BASE_W     = 36;
	localparam int RPAGES_W   = 13;
	localparam int LIMIT_W    = 13;
	localparam int COUNT_W    = 13;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_IDX_W  = 2;

	// reset values of the configuration registers
	localparam logic [RPAGES_W-1:0] RPAGES_RST = RPAGES_W'(4096);
	localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(4096);

	// register indexes (paddr[4:3])
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

	// flag bit positions inside a table entry, stamp sits above them
	localparam int FLAG_W     = 3;
	localparam int FLAG_VALID = 0;
	localparam int FLAG_DIRTY = 1;
	localparam int FLAG_READ  = 2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_VICTIM = 2'd2;

endpackage

>>> hdl/pfrm_ram.sv
module pfrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/page_fault_residency_manager.sv
// Page-fault residency manager. Takes one fault request at a time and returns one result
// per request. The page table (valid, dirty, was-read flags and a time stamp per page)
// lives in a single RAM with a registered read; every request inside the region reads the
// faulting entry and, unless no victim is found, updates and writes it back. A fault that
// must evict scans the table through the RAM read port at one entry per cycle from page 0,
// stopping at the first valid clean page, else evicting the first valid dirty page.
// After reset the table is cleared one entry per cycle and no request is taken in that
// time; configuration writes are taken throughout. A new request is taken while the
// previous result still waits in the output register.
module page_fault_residency_manager #(
	parameter int PAGES      = pfrm_pkg::PAGES_DEF,
	parameter int PAGE_BITS  = pfrm_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = pfrm_pkg::STAMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// fault requests
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pfrm_pkg::ADDR_W-1:0]       fault_address,
	input  logic                              write_fault,
	input  logic [pfrm_pkg::NOW_W-1:0]        now_seconds,
	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfrm_pkg::PAGE_OUT_W-1:0]   fault_page,
	output logic                              fetch_from_storage,
	output logic                              victim_taken,
	output logic [pfrm_pkg::PAGE_OUT_W-1:0]   victim_page,
	output logic                              victim_writeback,
	output logic [pfrm_pkg::STATUS_W-1:0]     status,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pfrm_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [pfrm_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [pfrm_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	import pfrm_pkg::*;

	localparam int IDX_W = $clog2(PAGES);
	localparam int APW   = ADDR_W - PAGE_BITS;
	localparam int CW    = ((APW > BASE_W) ? APW : BASE_W) + 1;
	localparam int SPW   = ((IDX_W + 1) > RPAGES_W) ? (IDX_W + 1) : RPAGES_W;
	localparam int ENT_W = FLAG_W + STAMP_BITS;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_LOOK  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_FWR   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	function automatic logic [PAGE_OUT_W-1:0] page_out(input logic [IDX_W-1:0] i);
		logic [PAGE_OUT_W+IDX_W-1:0] w;
		w = {{PAGE_OUT_W{1'b0}}, i};
		return w[PAGE_OUT_W-1:0];
	endfunction

	state_t state_q;

	logic [BASE_W-1:0]   base_q;
	logic [RPAGES_W-1:0] rpages_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [COUNT_W-1:0]  count_q;
	logic [IDX_W-1:0]    clr_q;

	logic [ADDR_W-1:0]     addr_q;
	logic                  wr_q;
	logic [STAMP_BITS-1:0] now_q;
	logic [IDX_W-1:0]      idx_q;
	// was-read bit of the faulting entry, kept across the rewrite
	logic                  read_keep_q;

	logic [SPW-1:0]   issue_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic             have_dirty_q;
	logic [IDX_W-1:0] dirty_q;

	logic [IDX_W-1:0]    res_page_q;
	logic                res_fetch_q;
	logic                res_taken_q;
	logic [IDX_W-1:0]    res_vpage_q;
	logic                res_wb_q;
	logic [STATUS_W-1:0] res_status_q;

	logic                  out_valid_q;
	logic [PAGE_OUT_W-1:0] out_page_q;
	logic                  out_fetch_q;
	logic                  out_taken_q;
	logic [PAGE_OUT_W-1:0] out_vpage_q;
	logic                  out_wb_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;

	logic [SPW-1:0] span;
	logic [CW-1:0]  diff;
	logic           in_range;
	logic           count_fits;
	logic           rd_valid;
	logic           rd_dirty;
	logic           rd_read;
	logic           scan_clean;
	logic           scan_end;
	logic           out_load;
	logic           cfg_wr;

	// effective region size and range check
	assign span = (SPW'(rpages_q) > SPW'(PAGES)) ? SPW'(PAGES) : SPW'(rpages_q);
	assign diff = CW'(addr_q[ADDR_W-1:PAGE_BITS]) - CW'(base_q);
	assign in_range = !diff[CW-1] && (diff[CW-2:0] < (CW-1)'(span));
	assign count_fits = ((COUNT_W+1)'(count_q) + (COUNT_W+1)'(1)) <= (COUNT_W+1)'(limit_q);

	// fields of the entry just read
	assign rd_valid = mem_rdata[FLAG_VALID];
	assign rd_dirty = mem_rdata[FLAG_DIRTY];
	assign rd_read  = mem_rdata[FLAG_READ];
	assign scan_clean = pend_s1 && rd_valid && !rd_dirty;
	assign scan_end   = !pend_s1 && (issue_q == span);

	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// table access
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_raddr = idx_q;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_CHECK: begin
				mem_raddr = diff[IDX_W-1:0];
			end
			S_SCAN: begin
				mem_raddr = issue_q[IDX_W-1:0];
				if (scan_clean) begin
					// clean victim only loses valid
					mem_we    = 1'b1;
					mem_waddr = pidx_s1;
					mem_wdata = mem_rdata;
					mem_wdata[FLAG_VALID] = 1'b0;
				end else if (scan_end && have_dirty_q) begin
					// dirty victim becomes invalid, clean, was-read, zero stamp
					mem_we    = 1'b1;
					mem_waddr = dirty_q;
					mem_wdata[FLAG_READ] = 1'b1;
				end
			end
			S_FWR: begin
				mem_we = 1'b1;
				mem_wdata[ENT_W-1:FLAG_W] = wr_q ? now_q : '0;
				mem_wdata[FLAG_VALID] = 1'b1;
				mem_wdata[FLAG_DIRTY] = wr_q;
				mem_wdata[FLAG_READ]  = read_keep_q;
			end
			default: begin
			end
		endcase
	end

	pfrm_ram #(
		.WIDTH(ENT_W),
		.DEPTH(PAGES)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[CFG_ADDR_W-1:3])
			REG_BASE:  prdata = CFG_DATA_W'(base_q);
			REG_PAGES: prdata = CFG_DATA_W'(rpages_q);
			REG_LIMIT: prdata = CFG_DATA_W'(limit_q);
			default:   prdata = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			count_q      <= '0;
			pend_s1      <= 1'b0;
			have_dirty_q <= 1'b0;
			out_valid_q  <= 1'b0;
			base_q       <= '0;
			rpages_q     <= RPAGES_RST;
			limit_q      <= LIMIT_RST;
		end else begin
			if (cfg_wr) begin
				case (paddr[CFG_ADDR_W-1:3])
					REG_BASE:  base_q   <= pwdata[BASE_W-1:0];
					REG_PAGES: rpages_q <= pwdata[RPAGES_W-1:0];
					REG_LIMIT: limit_q  <= pwdata[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= in_range ? S_LOOK : S_FIN;
				end
				S_LOOK: begin
					pend_s1      <= 1'b0;
					have_dirty_q <= 1'b0;
					if (rd_valid) begin
						state_q <= S_FWR;
					end else if (count_fits) begin
						count_q <= count_q + COUNT_W'(1);
						state_q <= S_FWR;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_clean) begin
						state_q <= S_FWR;
					end else if (scan_end) begin
						state_q <= have_dirty_q ? S_FWR : S_FIN;
					end else begin
						if (pend_s1 && rd_valid && rd_dirty && !have_dirty_q) begin
							have_dirty_q <= 1'b1;
						end
						pend_s1 <= (issue_q != span);
					end
				end
				S_FWR: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q <= fault_address;
				wr_q   <= write_fault;
				now_q  <= now_seconds[STAMP_BITS-1:0];
			end
			S_CHECK: begin
				idx_q       <= diff[IDX_W-1:0];
				res_fetch_q <= 1'b0;
				res_taken_q <= 1'b0;
				res_vpage_q <= '0;
				res_wb_q    <= 1'b0;
				if (in_range) begin
					res_page_q   <= diff[IDX_W-1:0];
					res_status_q <= STATUS_OK;
				end else begin
					res_page_q   <= '0;
					res_status_q <= STATUS_OUTSIDE;
				end
			end
			S_LOOK: begin
				read_keep_q <= rd_read;
				res_fetch_q <= !rd_valid && rd_read;
				issue_q     <= '0;
			end
			S_SCAN: begin
				if (scan_clean) begin
					res_taken_q <= 1'b1;
					res_vpage_q <= pidx_s1;
				end else if (scan_end) begin
					if (have_dirty_q) begin
						res_taken_q <= 1'b1;
						res_vpage_q <= dirty_q;
						res_wb_q    <= 1'b1;
					end else begin
						res_fetch_q  <= 1'b0;
						res_status_q <= STATUS_NO_VICTIM;
					end
				end else begin
					if (pend_s1 && rd_valid && rd_dirty && !have_dirty_q) begin
						dirty_q <= pidx_s1;
					end
					if (issue_q != span) begin
						pidx_s1 <= issue_q[IDX_W-1:0];
						issue_q <= issue_q + SPW'(1);
					end
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_page_q   <= page_out(res_page_q);
			out_fetch_q  <= res_fetch_q;
			out_taken_q  <= res_taken_q;
			out_vpage_q  <= page_out(res_vpage_q);
			out_wb_q     <= res_wb_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign fault_page         = out_page_q;
	assign fetch_from_storage = out_fetch_q;
	assign victim_taken       = out_taken_q;
	assign victim_page        = out_vpage_q;
	assign victim_writeback   = out_wb_q;
	assign status             = out_status_q;

endmodule

>>> hdl/pfrm_checker.sv
module pfrm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [pfrm_pkg::PAGE_OUT_W-1:0] fault_page,
	input logic                            fetch_from_storage,
	input logic                            victim_taken,
	input logic [pfrm_pkg::PAGE_OUT_W-1:0] victim_page,
	input logic                            victim_writeback,
	input logic [pfrm_pkg::STATUS_W-1:0]   status
);

	import pfrm_pkg::*;

	// one request in flight: acceptance closes the input side
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in flight");

	// victim fields are zero without an eviction
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !victim_taken |-> victim_page == '0 && !victim_writeback)
		else $error("victim fields set without an eviction");

	// a failed request neither evicts nor fetches
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> !victim_taken && !fetch_from_storage)
		else $error("failed request reports eviction or fetch");

	// an address outside the region reports page zero
	a_outside_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OUTSIDE |-> fault_page == '0)
		else $error("outside request reports a page");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fault_page) && $stable(status)
			&& $stable(victim_page))
		else $error("stalled result changed");

endmodule

bind page_fault_residency_manager pfrm_checker u_pfrm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.fault_page        (fault_page),
	.fetch_from_storage(fetch_from_storage),
	.victim_taken      (victim_taken),
	.victim_page       (victim_page),
	.victim_writeback  (victim_writeback),
	.status            (status)
);

>>> test/tb_page_fault_residency_manager.sv
`timescale 1ns / 100ps

module tb_page_fault_residency_manager;
	import pfrm_pkg::*;

	localparam int TBL_PAGES   = PAGES_DEF;
	localparam int OFFSET_BITS = PAGE_BITS_DEF;
	localparam int MAX_GAP     = 13;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 8;

	// one result as the block reports it
	typedef struct packed {
		logic [PAGE_OUT_W-1:0] fault_page;
		logic                  fetch;
		logic                  taken;
		logic [PAGE_OUT_W-1:0] victim_page;
		logic                  writeback;
		logic [STATUS_W-1:0]   status;
	} fault_result_t;

	// one line of the directed table: a register write or a fault request
	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] value;
		logic [ADDR_W-1:0]     addr;
		logic                  wr;
		logic [NOW_W-1:0]      now;
		bit                    has_want;
		fault_result_t         want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [ADDR_W-1:0]     fault_address;
	logic                  write_fault;
	logic [NOW_W-1:0]      now_seconds;
	logic                  out_valid;
	logic                  out_stall;
	logic [PAGE_OUT_W-1:0] fault_page;
	logic                  fetch_from_storage;
	logic                  victim_taken;
	logic [PAGE_OUT_W-1:0] victim_page;
	logic                  victim_writeback;
	logic [STATUS_W-1:0]   status;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow page table and registers
	bit                 pg_valid [TBL_PAGES];
	bit                 pg_dirty [TBL_PAGES];
	bit                 pg_read  [TBL_PAGES];
	logic [NOW_W-1:0]   pg_stamp [TBL_PAGES];
	int                 resident_pages;
	logic [BASE_W-1:0]  cfg_base;
	logic [RPAGES_W-1:0] cfg_pages;
	logic [LIMIT_W-1:0] cfg_limit;

	fault_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            mismatch_count = 0;
	bit            src_idle = 1'b1;
	bit            sink_idle = 1'b1;
	bit            hold_req = 1'b0;

	page_fault_residency_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.fault_address(fault_address),
		.write_fault(write_fault),
		.now_seconds(now_seconds),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fault_page(fault_page),
		.fetch_from_storage(fetch_from_storage),
		.victim_taken(victim_taken),
		.victim_page(victim_page),
		.victim_writeback(victim_writeback),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// work out the outcome of one fault and update the shadow table
	function automatic fault_result_t resolve_fault(input logic [ADDR_W-1:0] addr,
			input logic wr, input logic [NOW_W-1:0] now);
		fault_result_t res;
		logic [BASE_W-1:0] addr_page;
		logic [BASE_W-1:0] offs;
		int span;
		int idx;
		int i;
		int clean_at;
		int dirty_at;
		bit found_clean;
		bit found_dirty;
		res = '0;
		span = (int'(cfg_pages) > TBL_PAGES) ? TBL_PAGES : int'(cfg_pages);
		addr_page = addr[ADDR_W-1:OFFSET_BITS];
		offs = addr_page - cfg_base;
		if (addr_page < cfg_base || offs >= BASE_W'(span)) begin
			res.status = STATUS_OUTSIDE;
			return res;
		end
		idx = int'(offs);
		if (!pg_valid[idx]) begin
			if (resident_pages + 1 <= int'(cfg_limit)) begin
				resident_pages++;
			end else begin
				// first clean resident page wins, else first dirty one
				found_clean = 1'b0;
				found_dirty = 1'b0;
				clean_at = 0;
				dirty_at = 0;
				for (i = 0; i < span && !found_clean; i++) begin
					if (pg_valid[i] && !pg_dirty[i]) begin
						found_clean = 1'b1;
						clean_at = i;
					end else if (pg_valid[i] && !found_dirty) begin
						found_dirty = 1'b1;
						dirty_at = i;
					end
				end
				if (found_clean) begin
					pg_valid[clean_at] = 1'b0;
					res.taken = 1'b1;
					res.victim_page = PAGE_OUT_W'(clean_at);
				end else if (found_dirty) begin
					pg_valid[dirty_at] = 1'b0;
					pg_dirty[dirty_at] = 1'b0;
					pg_read[dirty_at] = 1'b1;
					pg_stamp[dirty_at] = '0;
					res.taken = 1'b1;
					res.victim_page = PAGE_OUT_W'(dirty_at);
					res.writeback = 1'b1;
				end else begin
					res.fault_page = PAGE_OUT_W'(idx);
					res.status = STATUS_NO_VICTIM;
					return res;
				end
			end
			res.fetch = pg_read[idx];
		end
		pg_valid[idx] = 1'b1;
		pg_dirty[idx] = wr;
		pg_stamp[idx] = wr ? now : '0;
		res.fault_page = PAGE_OUT_W'(idx);
		return res;
	endfunction

	function automatic fault_result_t plain_result(input int page, input logic [STATUS_W-1:0] st);
		fault_result_t res;
		res = '0;
		res.fault_page = PAGE_OUT_W'(page);
		res.status = st;
		return res;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.value = value;
		row.addr = '0;
		row.wr = 1'b0;
		row.now = '0;
		row.has_want = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t fault_row(input logic [ADDR_W-1:0] addr, input logic wr,
			input logic [NOW_W-1:0] now, input bit has_want, input fault_result_t want);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = '0;
		row.value = '0;
		row.addr = addr;
		row.wr = wr;
		row.now = now;
		row.has_want = has_want;
		row.want = want;
		return row;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// offer one fault request and record its expected result on acceptance
	task automatic send_fault(input logic [ADDR_W-1:0] addr, input logic wr,
			input logic [NOW_W-1:0] now, input bit has_want, input fault_result_t want);
		int gap;
		fault_result_t predicted;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		fault_address = addr;
		write_fault = wr;
		now_seconds = now;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = resolve_fault(addr, wr, now);
		pending_results.push_back(has_want ? want : predicted);
	endtask

	// stop offering and let every outstanding request finish
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write followed by a read back
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] got;
		logic [CFG_DATA_W-1:0] want;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_BASE: begin
				cfg_base = value[BASE_W-1:0];
				want = CFG_DATA_W'(cfg_base);
			end
			REG_PAGES: begin
				cfg_pages = value[RPAGES_W-1:0];
				want = CFG_DATA_W'(cfg_pages);
			end
			default: begin
				cfg_limit = value[LIMIT_W-1:0];
				want = CFG_DATA_W'(cfg_limit);
			end
		endcase
		check_field("register read back", want, got);
	endtask

	// one random phase with its own region and limit
	task automatic run_phase(input logic [BASE_W-1:0] base, input logic [RPAGES_W-1:0] pages,
			input logic [LIMIT_W-1:0] limit, input int items, input bit hold_first,
			input bit pause_mid);
		int n;
		int span;
		int pick;
		logic [BASE_W-1:0] page;
		logic [ADDR_W-1:0] addr;
		wait_idle();
		cfg_write(REG_BASE, CFG_DATA_W'(base));
		cfg_write(REG_PAGES, CFG_DATA_W'(pages));
		cfg_write(REG_LIMIT, CFG_DATA_W'(limit));
		span = (int'(pages) > TBL_PAGES) ? TBL_PAGES : int'(pages);
		if (hold_first) begin
			hold_req = 1'b1;
			src_idle = 1'b0;
		end
		for (n = 0; n < items; n++) begin
			if (hold_first && n == 12)
				src_idle = 1'b1;
			if (pause_mid && n == items / 2)
				wait_idle();
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				addr = ADDR_W'({$urandom, $urandom});
			end else begin
				// mostly inside the region, a few just past either end
				if (pick < 14)
					page = (base != '0 && pick[0]) ? base - 1'b1 : base + span;
				else if (span > 32 && $urandom_range(0, 3) != 0)
					page = base + $urandom_range(0, 31);
				else
					page = base + $urandom_range(0, span - 1);
				addr = {page, OFFSET_BITS'($urandom)};
			end
			send_fault(addr, 1'($urandom_range(0, 1)), NOW_W'({$urandom, $urandom}), 1'b0, '0);
		end
	endtask

	// result side: random stalls per result, one long hold on request
	initial begin : result_sink
		int gap;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_req) begin
				gap = LONG_HOLD;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
		end
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin : result_check
		fault_result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got page %0h status %0h",
					$time, fault_page, status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("fault_page", 64'(want.fault_page), 64'(fault_page));
				check_field("fetch_from_storage", 64'(want.fetch), 64'(fetch_from_storage));
				check_field("victim_taken", 64'(want.taken), 64'(victim_taken));
				check_field("victim_page", 64'(want.victim_page), 64'(victim_page));
				check_field("victim_writeback", 64'(want.writeback), 64'(victim_writeback));
				check_field("status", 64'(want.status), 64'(status));
			end
		end
	end

	// overall time limit
	initial begin
		#1000000;
		$display("tb_page_fault_residency_manager: FAIL");
		$finish;
	end

	initial begin : stimulus
		int k;
		int ph;
		stim_row_t row;
		logic [BASE_W-1:0] base;
		logic [RPAGES_W-1:0] pages;
		logic [LIMIT_W-1:0] limit;
		arst_n = 1'b0;
		in_valid = 1'b0;
		fault_address = '0;
		write_fault = 1'b0;
		now_seconds = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (k = 0; k < TBL_PAGES; k++) begin
			pg_valid[k] = 1'b0;
			pg_dirty[k] = 1'b0;
			pg_read[k] = 1'b0;
			pg_stamp[k] = '0;
		end
		resident_pages = 0;
		cfg_base = '0;
		cfg_pages = RPAGES_RST;
		cfg_limit = LIMIT_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: extremes, both victim kinds, fetch, resident rewrite, error codes
		directed_rows.push_back(fault_row(48'h0, 1'b0, 56'h0, 1'b1, plain_result(0, STATUS_OK)));
		directed_rows.push_back(fault_row(48'hFFFF_FFFF_FFFF, 1'b1, {NOW_W{1'b1}}, 1'b1,
			plain_result(0, STATUS_OUTSIDE)));
		directed_rows.push_back(fault_row(48'h0000_00FF_FFFF, 1'b1, {NOW_W{1'b1}}, 1'b1,
			plain_result(4095, STATUS_OK)));
		directed_rows.push_back(fault_row(48'h0ABC, 1'b1, 56'h12_3456_789A_BCDE, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_PAGES, 64'd8));
		directed_rows.push_back(cfg_row(REG_LIMIT, 64'd2));
		directed_rows.push_back(fault_row(48'h1000, 1'b0, 56'h5, 1'b0, '0));
		directed_rows.push_back(fault_row(48'h0FFF, 1'b0, 56'h6, 1'b0, '0));
		directed_rows.push_back(fault_row(48'h7FFF, 1'b1, 56'hAA_5555_AAAA_5555, 1'b0, '0));
		directed_rows.push_back(fault_row(48'h8000, 1'b0, 56'h0, 1'b1,
			plain_result(0, STATUS_OUTSIDE)));
		directed_rows.push_back(cfg_row(REG_LIMIT, 64'd0));
		directed_rows.push_back(fault_row(48'h3456, 1'b0, 56'h7, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_PAGES, 64'd1));
		directed_rows.push_back(fault_row(48'h0123, 1'b0, 56'h8, 1'b1,
			plain_result(0, STATUS_NO_VICTIM)));
		directed_rows.push_back(cfg_row(REG_PAGES, 64'd0));
		directed_rows.push_back(fault_row(48'h0, 1'b1, 56'h9, 1'b1,
			plain_result(0, STATUS_OUTSIDE)));
		directed_rows.push_back(cfg_row(REG_BASE, 64'hF_FFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_PAGES, 64'd8191));
		directed_rows.push_back(cfg_row(REG_LIMIT, 64'd4096));
		directed_rows.push_back(fault_row(48'hFFFF_FFFF_FFFF, 1'b1, {NOW_W{1'b1}}, 1'b0, '0));
		directed_rows.push_back(fault_row(48'hFFFF_FFFF_EFFF, 1'b0, 56'h0, 1'b1,
			plain_result(0, STATUS_OUTSIDE)));
		directed_rows.push_back(fault_row(48'h0, 1'b0, 56'h0, 1'b1,
			plain_result(0, STATUS_OUTSIDE)));
		directed_rows.push_back(cfg_row(REG_LIMIT, 64'd1));
		directed_rows.push_back(fault_row(48'hFFFF_FFFF_F123, 1'b0, 56'h3, 1'b0, '0));

		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.is_cfg) begin
				wait_idle();
				cfg_write(row.reg_idx, row.value);
			end else begin
				send_fault(row.addr, row.wr, row.now, row.has_want, row.want);
			end
		end

		// random phases over small regions, a clamped full region and an unlimited cache
		for (ph = 0; ph < 6; ph++) begin
			pages = RPAGES_W'($urandom_range(1, 24));
			case (ph)
				0: base = '0;
				1: begin
					base = {BASE_W{1'b1}} - 15;
					pages = RPAGES_W'(16);
				end
				default: base = BASE_W'({$urandom, $urandom});
			endcase
			limit = LIMIT_W'($urandom_range(0, int'(pages) + 1));
			src_idle = (ph != 4);
			sink_idle = (ph != 4);
			run_phase(base, pages, limit, 18, ph == 2, ph == 3);
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
		run_phase(BASE_W'({$urandom, $urandom}), RPAGES_W'(8191),
			LIMIT_W'($urandom_range(0, 3)), 12, 1'b0, 1'b0);
		run_phase('0, RPAGES_W'(4096), LIMIT_W'(4096), 10, 1'b0, 1'b0);

		wait_idle();
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected 0 outstanding",
				$time, pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb_page_fault_residency_manager: PASS");
		else
			$display("tb_page_fault_residency_manager: FAIL");
		$finish;
	end

endmodule
